/* sv/spq_pkg.sv */
// spq_pkg: shared sizes, entry and command types, status and action codes
// for the sorted priority queue; no dependencies
`default_nettype none

package spq_pkg;

   localparam int DEPTH     = 64;
   localparam int ID_BITS   = 16;
   localparam int PRIO_BITS = 8;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int CAP_BITS  = 7;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

   typedef enum logic {
      ACT_ENQUEUE = 1'b0,
      ACT_DEQUEUE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type new_entry;
   } cmd_type;

endpackage

`default_nettype wire

/* sv/spq_cell.sv */
// spq_cell: one slot of the sorted row; keeps its entry, takes the new
// entry, or takes a neighbor's entry. depends on spq_pkg
`default_nettype none

module spq_cell (
   input  wire                    clock,
   input  spq_pkg::cmd_type       cmd,
   input  wire                    live,
   input  wire                    left_stays,
   input  spq_pkg::entry_type     left_entry,
   input  spq_pkg::entry_type     right_entry,
   output spq_pkg::entry_type     entry_out,
   output logic                   stays_out
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // stays put on insert when it ranks at or above the newcomer
   assign stays_out = live && (entry_ff.prio >= cmd.new_entry.prio);
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.deq) begin
         entry_in = right_entry;
      end else if (cmd.enq && !stays_out) begin
         if (left_stays) begin
            entry_in = cmd.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

/* sv/sorted_priority_queue.sv */
// sorted_priority_queue: top level; row of spq_cell slots, entry count,
// capacity register and registered response. depends on spq_pkg, spq_cell
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tuser action, tdata id + priority
//   rsp      out  rsp_tvalid/tready     tuser status, tdata id/prio/count
//   csr      in   psel/penable/pready   capacity at byte address 0
//
// all slots compare against the new priority and shift in parallel, so one
// request is accepted per clock while the response register can take it;
// the response sits in an output register; a new request is taken while that
// register is empty or being drained in the same cycle
// reset clears the entry count and response valid and sets capacity to 64;
// slot contents are not reset, only slots below the count are ever read
`default_nettype none

module sorted_priority_queue (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [15:0] new_id, [23:16] new_priority
   input  wire  [0:0]  req_tuser,   // [0] action
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] out_id, [23:16] out_priority,
                                    // [30:24] held_count, [31] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // configuration port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DEPTH    = spq_pkg::DEPTH;
   localparam int CNT_BITS = spq_pkg::CNT_BITS;

   // capacity register
   logic [spq_pkg::CAP_BITS-1:0] cap_ff, cap_in;
   logic                         csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == 1'b0);
   assign cap_in     = csr_wr ? csr_pwdata[spq_pkg::CAP_BITS-1:0] : cap_ff;
   assign csr_prdata = (csr_paddr[2] == 1'b0)
                       ? {{(32-spq_pkg::CAP_BITS){1'b0}}, cap_ff} : 32'd0;

   // request decode
   logic                  accept;
   logic                  is_deq;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  full, empty;
   spq_pkg::cmd_type      cmd;
   spq_pkg::status_type   status;

   assign accept = req_tvalid && req_tready;
   assign is_deq = (spq_pkg::action_type'(req_tuser[0]) == spq_pkg::ACT_DEQUEUE);

   // the limit is the smaller of capacity and depth
   assign full  = (32'(count_ff) >= 32'(cap_ff)) || (32'(count_ff) >= 32'(DEPTH));
   assign empty = (count_ff == '0);

   assign cmd.enq            = accept && !is_deq && !full;
   assign cmd.deq            = accept && is_deq && !empty;
   assign cmd.new_entry.id   = req_tdata[15:0];
   assign cmd.new_entry.prio = req_tdata[23:16];

   always_comb begin
      count_in = count_ff;
      if (cmd.enq) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      if (is_deq) begin
         status = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
      end else begin
         status = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
      end
   end

   // row of slots, head at index 0
   spq_pkg::entry_type slot_entry [DEPTH];
   logic [DEPTH-1:0]   slot_stays;
   logic [DEPTH-1:0]   slot_live;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_e, right_e;
      logic               left_s;

      assign slot_live[i] = (CNT_BITS'(i) < count_ff);

      // the head takes the newcomer whenever it does not stay
      if (i == 0) begin : g_head
         assign left_s = 1'b1;
         assign left_e = cmd.new_entry;
      end else begin : g_body
         assign left_s = slot_stays[i-1];
         assign left_e = slot_entry[i-1];
      end

      // the tail slot goes dead on dequeue, so its fill value is arbitrary
      if (i == DEPTH - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = slot_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .live        (slot_live[i]),
         .left_stays  (left_s),
         .left_entry  (left_e),
         .right_entry (right_e),
         .entry_out   (slot_entry[i]),
         .stays_out   (slot_stays[i])
      );
   end

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type       rsp_status_ff, rsp_status_in;
   spq_pkg::entry_type        rsp_entry_ff, rsp_entry_in;
   logic [CNT_BITS-1:0]       rsp_count_ff, rsp_count_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_entry_in  = cmd.deq ? slot_entry[0] : '0;
         rsp_count_in  = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= spq_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, 7'(rsp_count_ff), rsp_entry_ff.prio, rsp_entry_ff.id};

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("entry count beyond depth");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request left no response");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.enq |=> (count_ff == $past(count_ff) + CNT_BITS'(1)))
      else $error("insert did not grow the count");

   a_deq_head: assert property (@(posedge clock) disable iff (reset)
      cmd.deq |=> (rsp_entry_ff == $past(slot_entry[0])
                   && rsp_status_ff == spq_pkg::ST_DONE))
      else $error("dequeue response is not the old head");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !cmd.enq && !cmd.deq) |=> $stable(count_ff))
      else $error("rejected request changed the count");

endmodule

`default_nettype wire

/* bench/spq_checker.sv */
`timescale 1ns / 1ps
// spq_checker: watches the request, response and csr channels of the sorted
// priority queue, keeps its own sorted entry list and compares every response
// depends on spq_pkg
module spq_checker #(
   parameter logic [2:0] CAPACITY_ADDR = 3'd0
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [23:0] req_tdata,   // [15:0] new_id, [23:16] new_priority
   input  wire  [0:0]  req_tuser,   // [0] action
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [31:0] rsp_tdata,   // [15:0] out_id, [23:16] out_priority, [30:24] held_count
   input  wire  [1:0]  rsp_tuser,   // [1:0] status
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   input  wire  [31:0] csr_prdata,
   input  wire         csr_pready,
   output int          failures,
   output int          pending
);
   import spq_pkg::*;

   typedef struct {
      status_type           status;
      logic [ID_BITS-1:0]   id;
      logic [PRIO_BITS-1:0] prio;
      logic [CAP_BITS-1:0]  held;
   } queue_reply;

   entry_type           mirror_store [DEPTH];
   int                  mirror_count;
   logic [CAP_BITS-1:0] mirror_capacity;
   queue_reply          expected_replies [$];

   initial failures = 0;
   initial pending = 0;

   // apply one request to the mirror and return the reply it must produce
   function automatic queue_reply serve_request(action_type act,
                                                logic [ID_BITS-1:0] nid,
                                                logic [PRIO_BITS-1:0] npr);
      queue_reply r;
      int         limit;
      int         i;
      r.status = ST_DONE;
      r.id     = '0;
      r.prio   = '0;
      limit = (mirror_capacity > DEPTH) ? DEPTH : int'(mirror_capacity);
      if (act == ACT_ENQUEUE) begin
         if (mirror_count >= limit) begin
            r.status = ST_FULL;
         end else begin
            // equal priorities stay ahead of the newcomer
            i = mirror_count;
            while (i > 0 && mirror_store[i-1].prio < npr) begin
               mirror_store[i] = mirror_store[i-1];
               i--;
            end
            mirror_store[i].id   = nid;
            mirror_store[i].prio = npr;
            mirror_count++;
         end
      end else begin
         if (mirror_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.id   = mirror_store[0].id;
            r.prio = mirror_store[0].prio;
            for (i = 1; i < mirror_count; i++)
               mirror_store[i-1] = mirror_store[i];
            mirror_count--;
         end
      end
      r.held = CAP_BITS'(mirror_count);
      return r;
   endfunction

   always @(posedge clock) begin
      queue_reply want;
      if (reset) begin
         mirror_count    = 0;
         mirror_capacity = CAP_RESET;
         expected_replies.delete();
      end else begin
         // responses first: a reply never leaves in the cycle of its request
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               $error("response with no request outstanding: %h/%h", rsp_tuser, rsp_tdata);
               failures++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  failures++;
               end
               if (rsp_tdata[15:0] !== want.id) begin
                  $error("out_id: expected %h, got %h", want.id, rsp_tdata[15:0]);
                  failures++;
               end
               if (rsp_tdata[23:16] !== want.prio) begin
                  $error("out_priority: expected %h, got %h", want.prio, rsp_tdata[23:16]);
                  failures++;
               end
               if (rsp_tdata[30:24] !== want.held) begin
                  $error("held_count: expected %0d, got %0d", want.held, rsp_tdata[30:24]);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_replies.push_back(serve_request(action_type'(req_tuser[0]),
                                                     req_tdata[15:0], req_tdata[23:16]));
         if (csr_psel && csr_penable && csr_pready && csr_paddr == CAPACITY_ADDR) begin
            if (csr_pwrite) begin
               mirror_capacity = csr_pwdata[CAP_BITS-1:0];
            end else if (csr_prdata[CAP_BITS-1:0] !== mirror_capacity) begin
               $error("capacity: expected %0d, got %0d", mirror_capacity,
                      csr_prdata[CAP_BITS-1:0]);
               failures++;
            end
         end
      end
      pending = expected_replies.size();
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// tb: stimulus and verdict for the sorted priority queue; directed requests
// then random phases under several capacities. depends on spq_pkg,
// sorted_priority_queue and spq_checker
module tb;
   import spq_pkg::*;

   // csr map: capacity at index 0, index 1 is not a register
   localparam logic [2:0] CAPACITY_ADDR = 3'd0;
   localparam logic [2:0] UNUSED_ADDR   = 3'd4;
   // response is registered, so the settle wait covers anything in flight
   localparam int SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [15:0] new_id, [23:16] new_priority
   logic [0:0]  req_tuser = '0;   // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [15:0] out_id, [23:16] out_priority, [30:24] held_count
   logic [1:0]  rsp_tuser;        // [1:0] status
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int pending;
   int send_idle_pct = 12;   // chance of a gap before each request
   int recv_idle_pct = 45;   // chance of holding off the response per cycle

   // handshake flags captured at the rising edge, read at the falling edge
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   sorted_priority_queue i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   spq_checker #(.CAPACITY_ADDR(CAPACITY_ADDR)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      csr_taken <= csr_psel && csr_penable && csr_pready;
   end

   // receiver stalls at random, decided fresh every cycle
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   // called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so back-to-back requests never drop valid
   task automatic issue_request(input action_type act, input logic [15:0] id,
                                input logic [7:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = {prio, id};
      do @(negedge clock); while (!req_taken);
   endtask

   // sender holds off until every response is back, then lets things settle
   task automatic drain_queue();
      req_tvalid = 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // two-phase apb transfer; the checker follows writes and checks reads
   task automatic csr_access(input logic wr, input logic [2:0] addr,
                             input logic [31:0] data);
      csr_psel    = 1'b1;
      csr_pwrite  = wr;
      csr_paddr   = addr;
      csr_pwdata  = data;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(negedge clock); while (!csr_taken);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // capacity write with junk in the upper bits, then read it back
   task automatic set_capacity(input logic [6:0] cap);
      csr_access(1'b1, CAPACITY_ADDR, {25'($urandom), cap});
      csr_access(1'b0, CAPACITY_ADDR, '0);
   endtask

   initial begin
      int            enq_pct;
      logic [7:0]    prio;
      logic [6:0]    cap;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // directed: empty dequeue, extreme fields, ties leaving in arrival order
      issue_request(ACT_DEQUEUE, 16'hffff, 8'hff);
      issue_request(ACT_ENQUEUE, 16'h0000, 8'h00);
      issue_request(ACT_ENQUEUE, 16'hffff, 8'hff);
      issue_request(ACT_ENQUEUE, 16'h1234, 8'h80);
      issue_request(ACT_ENQUEUE, 16'h5555, 8'h80);
      issue_request(ACT_ENQUEUE, 16'haaaa, 8'h80);
      repeat (6) issue_request(ACT_DEQUEUE, 16'($urandom), 8'($urandom));
      drain_queue();

      // write to an address with no register must leave capacity alone
      csr_access(1'b1, UNUSED_ADDR, 32'h0000_0011);
      csr_access(1'b0, CAPACITY_ADDR, '0);

      // capacity zero rejects every enqueue
      set_capacity(7'd0);
      issue_request(ACT_ENQUEUE, 16'h0001, 8'h01);
      issue_request(ACT_DEQUEUE, 16'h0000, 8'h00);
      drain_queue();

      // small capacity reaches full, then is lowered below the held count
      set_capacity(7'd2);
      issue_request(ACT_ENQUEUE, 16'h00a1, 8'h10);
      issue_request(ACT_ENQUEUE, 16'h00a2, 8'h20);
      issue_request(ACT_ENQUEUE, 16'h00a3, 8'h30);
      drain_queue();
      set_capacity(7'd1);
      issue_request(ACT_ENQUEUE, 16'h00a4, 8'hff);
      issue_request(ACT_DEQUEUE, 16'h0000, 8'h00);
      issue_request(ACT_ENQUEUE, 16'h00a5, 8'hff);
      issue_request(ACT_DEQUEUE, 16'h0000, 8'h00);
      issue_request(ACT_DEQUEUE, 16'h0000, 8'h00);
      drain_queue();

      // random: nine blocks of 100 requests, each under its own capacity;
      // the first block is enqueue heavy with capacity above the depth so
      // the store fills right up, later blocks wander between full and empty
      for (int blk = 0; blk < 9; blk++) begin
         if (blk < 3) begin
            send_idle_pct = 12;
            recv_idle_pct = 45;
         end else if (blk < 6) begin
            send_idle_pct = 45;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (blk)
            0:       cap = 7'd127;
            4:       cap = 7'd1;
            8:       cap = 7'd64;
            default: cap = 7'($urandom_range(127));
         endcase
         drain_queue();
         set_capacity(cap);
         enq_pct = 90;
         for (int n = 0; n < 100; n++) begin
            if (blk != 0 && n % 25 == 0) begin
               case ($urandom_range(3))
                  0:       enq_pct = 85;
                  1:       enq_pct = 55;
                  2:       enq_pct = 40;
                  default: enq_pct = 15;
               endcase
            end
            // narrow priorities now and then so ties are common
            prio = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
            issue_request(($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE,
                          16'($urandom), prio);
         end
      end

      // end of stimulus: wait out every response, then settle
      drain_queue();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
